>>> hw/rtl/lkc_pkg.sv
// lkc_pkg: word types, entry and cell chain types, field widths and codes
// for the LRU keyed cache. No dependencies.
package lkc_pkg;

	localparam int KEY_W    = 64;
	localparam int HANDLE_W = 32;
	localparam int LEN_W    = 24;
	localparam int CFG_W    = 4;

	localparam logic [CFG_W-1:0] CAP_RESET = 4'd5;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef struct packed {
		logic                op;
		logic [KEY_W-1:0]    key;
		logic [HANDLE_W-1:0] value;
		logic [LEN_W-1:0]    length;
	} req_t;

	typedef struct packed {
		logic                hit;
		logic [HANDLE_W-1:0] value_out;
		logic [LEN_W-1:0]    length_out;
		logic                evicted;
		logic [KEY_W-1:0]    evicted_key;
	} rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0]    key;
		logic [HANDLE_W-1:0] value;
		logic [LEN_W-1:0]    length;
	} entry_t;

	// gathered along the row from the least recent cell toward the front
	typedef struct packed {
		logic                hit;
		logic [HANDLE_W-1:0] value;
		logic [LEN_W-1:0]    length;
		logic [KEY_W-1:0]    evk;
	} chain_t;

endpackage

>>> hw/rtl/lkc_cell.sv
// lkc_cell: one recency slot of the cache row. Holds an entry, takes its
// neighbor's entry on shift, and adds its match into the row chain. Uses lkc_pkg.
module lkc_cell (
	input  logic                       clk,
	input  logic                       valid,
	input  logic                       last,
	input  logic                       shift,
	input  logic [lkc_pkg::KEY_W-1:0]  lookup_key,
	input  lkc_pkg::entry_t            prev,
	input  lkc_pkg::chain_t            chain_in,
	output lkc_pkg::entry_t            cur,
	output lkc_pkg::chain_t            chain_out
);
	import lkc_pkg::*;

	entry_t entry_q;
	logic   match;

	always_ff @(posedge clk) begin
		if (shift) begin
			entry_q <= prev;
		end
	end

	assign match = valid && (entry_q.key == lookup_key);
	assign cur   = entry_q;

	always_comb begin
		chain_out.hit    = chain_in.hit | match;
		chain_out.value  = chain_in.value | ({HANDLE_W{match}} & entry_q.value);
		chain_out.length = chain_in.length | ({LEN_W{match}} & entry_q.length);
		chain_out.evk    = chain_in.evk | ({KEY_W{last}} & entry_q.key);
	end

endmodule

>>> hw/rtl/lru_keyed_cache_core.sv
// lru_keyed_cache_core: fully associative cache with LRU replacement, built
// as a row of lkc_cell slots kept in recency order. Uses lkc_pkg, lkc_cell.
//
// Usage:
//   Request channel req/req_valid/req_stall carries one word: op (read or
//   write), key, value, length. Response channel rsp/rsp_valid/rsp_stall
//   returns one word per request: hit, value_out, length_out, evicted,
//   evicted_key. Cell 0 holds the most recent entry; a hit or insert moves
//   the entry to cell 0 and the cells in front of it step back by one.
//   rsp_valid rises in the cycle after acceptance. Throughput is one word
//   per cycle while req_stall is low: all cells compare the key at once and
//   the row shifts in the same cycle. The response register holds one word;
//   while it waits under rsp_stall, req_stall is raised and no request is
//   taken. capacity is written through cap_we/cap_wdata; the user must write
//   it only while the cache is idle; the block does not enforce this. 0 acts
//   as 1 and values above MAX_ENTRIES act as MAX_ENTRIES. Lowering it does
//   not drop entries; later inserts evict one entry each. Reset empties the
//   cache, clears rsp_valid and sets capacity to 5. No clearing pass is needed.
module lru_keyed_cache_core #(
	parameter int MAX_ENTRIES = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  lkc_pkg::req_t             req,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output lkc_pkg::rsp_t             rsp,
	input  logic                      cap_we,
	input  logic [lkc_pkg::CFG_W-1:0] cap_wdata
);
	import lkc_pkg::*;

	localparam int CW    = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W = (CW > CFG_W) ? CW : CFG_W;

	logic [CFG_W-1:0] capacity_q;
	logic [CW-1:0]    count_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic             accept;
	logic [CMP_W-1:0] cap_ext;
	logic [CW-1:0]    cap_eff;
	logic             any_hit;
	logic             is_write;
	logic             do_insert;
	logic             do_evict;
	entry_t           front;
	rsp_t             rsp_d;

	logic [MAX_ENTRIES-1:0] cell_valid;
	logic [MAX_ENTRIES-1:0] cell_last;
	logic [MAX_ENTRIES-1:0] cell_shift;
	entry_t                 cur   [MAX_ENTRIES];
	entry_t                 prev  [MAX_ENTRIES];
	chain_t                 chain [MAX_ENTRIES+1];

	assign req_stall = rsp_valid_q & rsp_stall;
	assign accept    = req_valid & ~req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// effective capacity, clamped to 1..MAX_ENTRIES
	always_comb begin
		cap_ext = CMP_W'(capacity_q);
		if (capacity_q == '0) begin
			cap_eff = CW'(1);
		end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
			cap_eff = CW'(MAX_ENTRIES);
		end else begin
			cap_eff = CW'(cap_ext);
		end
	end

	assign any_hit   = chain[0].hit;
	assign is_write  = (req.op == OP_WRITE);
	assign do_insert = is_write & ~any_hit;
	assign do_evict  = do_insert & (count_q >= cap_eff);

	always_comb begin
		front.key = req.key;
		if (is_write) begin
			front.value  = req.value;
			front.length = req.length;
		end else begin
			front.value  = chain[0].value;
			front.length = chain[0].length;
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			cell_valid[i] = CW'(i) < count_q;
			cell_last[i]  = count_q == CW'(i + 1);
			if (any_hit) begin
				cell_shift[i] = accept & chain[i].hit;
			end else begin
				cell_shift[i] = accept & do_insert &
					((CW'(i) < count_q) | (~do_evict & (CW'(i) == count_q)));
			end
		end
	end

	assign chain[MAX_ENTRIES] = '0;

	for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
		if (g == 0) begin : g_front
			assign prev[g] = front;
		end else begin : g_next
			assign prev[g] = cur[g-1];
		end

		lkc_cell u_cell (
			.clk        (clk),
			.valid      (cell_valid[g]),
			.last       (cell_last[g]),
			.shift      (cell_shift[g]),
			.lookup_key (req.key),
			.prev       (prev[g]),
			.chain_in   (chain[g+1]),
			.cur        (cur[g]),
			.chain_out  (chain[g])
		);
	end

	always_comb begin
		rsp_d.hit         = any_hit;
		rsp_d.value_out   = (any_hit & ~is_write) ? chain[0].value : '0;
		rsp_d.length_out  = (any_hit & ~is_write) ? chain[0].length : '0;
		rsp_d.evicted     = do_evict;
		rsp_d.evicted_key = do_evict ? chain[0].evk : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= CAP_RESET;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cap_we) begin
				capacity_q <= cap_wdata;
			end
			if (accept && do_insert && !do_evict) begin
				count_q <= count_q + CW'(1);
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES))
		else $error("entry count above row length");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && do_insert && !do_evict) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert without eviction did not grow the count");

	a_evict_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && do_evict) |-> (count_q != '0 && $onehot(cell_last)))
		else $error("eviction from an empty row");

	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (rsp_valid && (rsp.hit == $past(any_hit))))
		else $error("response word not registered after accept");

endmodule
